@@ src/utfga_pkg.sv @@
// Shared widths, register indexes, glyph kinds and types of the glyph address stream.
package utfga_pkg;

  localparam int BYTE_W      = 8;
  localparam int CODE_W      = 11;
  localparam int KIND_W      = 2;
  localparam int ADDR_W      = 16;
  localparam int BLANK_W     = 3;
  localparam int WIDTH_W     = 4;
  localparam int LEAD_W      = 5;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 42;

  localparam int REMAP_RANGES_DEF = 2;
  localparam int FONT_RANGES_DEF  = 3;

  // Register map: remap ranges first, then glyph ranges.
  localparam logic [CFG_INDEX_W-1:0] REG_REMAP_BASE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FONT_BASE  = 3'd2;

  localparam logic [KIND_W-1:0] GLYPH_BLANK = 2'd0;
  localparam logic [KIND_W-1:0] GLYPH_FONT  = 2'd1;
  localparam logic [KIND_W-1:0] GLYPH_BOX   = 2'd2;

  localparam logic [WIDTH_W-1:0] WIDTH_MIN = 4'd1;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX = 4'd8;

  typedef struct packed {
    logic [CODE_W-1:0] target;
    logic [CODE_W-1:0] hi;
    logic [CODE_W-1:0] lo;
  } remap_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [WIDTH_W-1:0] width;
    logic [CODE_W-1:0]  hi;
    logic [CODE_W-1:0]  lo;
  } font_t;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
  } code_stage_t;

  function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] raw);
    logic [WIDTH_W-1:0] w;
    w = raw;
    if (raw < WIDTH_MIN) begin
      w = WIDTH_MIN;
    end else if (raw > WIDTH_MAX) begin
      w = WIDTH_MAX;
    end
    return w;
  endfunction

endpackage

@@ src/utfga_if.sv @@
// Stream interfaces for text bytes in and glyph results out.
interface utfga_byte_if;
  logic                         valid;
  logic                         ready;
  logic [utfga_pkg::BYTE_W-1:0] byte_in;
  logic                         last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface utfga_glyph_if;
  logic                          valid;
  logic                          ready;
  logic [utfga_pkg::CODE_W-1:0]  code_point;
  logic [utfga_pkg::KIND_W-1:0]  glyph_kind;
  logic [utfga_pkg::ADDR_W-1:0]  rom_address;
  logic [utfga_pkg::BLANK_W-1:0] blank_columns;

  modport source (output valid, output code_point, output glyph_kind,
                  output rom_address, output blank_columns, input ready);
  modport sink   (input valid, input code_point, input glyph_kind,
                  input rom_address, input blank_columns, output ready);
endinterface

@@ src/utfga_cfg.sv @@
// Configuration register file for the remap and glyph ranges.
module utfga_cfg #(
  parameter int REMAP_RANGES = utfga_pkg::REMAP_RANGES_DEF,
  parameter int FONT_RANGES  = utfga_pkg::FONT_RANGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [utfga_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [utfga_pkg::CFG_DATA_W-1:0]  cfg_data,
  output utfga_pkg::remap_t [REMAP_RANGES-1:0] remap,
  output utfga_pkg::font_t  [FONT_RANGES-1:0]  font
);
  import utfga_pkg::*;

  for (genvar i = 0; i < REMAP_RANGES; i++) begin : g_remap
    always_ff @(posedge clk) begin
      if (rst) begin
        remap[i] <= '0;
      end else if (cfg_write && cfg_index == REG_REMAP_BASE + CFG_INDEX_W'(i)) begin
        remap[i] <= cfg_data[$bits(remap_t)-1:0];
      end
    end
  end

  for (genvar i = 0; i < FONT_RANGES; i++) begin : g_font
    always_ff @(posedge clk) begin
      if (rst) begin
        font[i] <= '0;
      end else if (cfg_write && cfg_index == REG_FONT_BASE + CFG_INDEX_W'(i)) begin
        font[i] <= cfg_data[$bits(font_t)-1:0];
      end
    end
  end

endmodule

@@ src/utfga_decode.sv @@
// UTF-8 byte decoder: lead hold, continuation skip, raw code register.
module utfga_decode (
  input  logic                   clk,
  input  logic                   rst,
  utfga_byte_if.sink             byte_ch,
  input  logic                   next_ready,
  output utfga_pkg::code_stage_t stage
);
  import utfga_pkg::*;

  localparam logic [BYTE_W-1:0] ASCII_MAX = 8'h7f;
  localparam logic [BYTE_W-1:0] LEAD_MIN  = 8'hc0;
  localparam logic [BYTE_W-1:0] LEAD_MAX  = 8'hdf;

  logic              ready;
  logic              fire;
  logic              cont;
  logic              emit;
  logic [CODE_W-1:0] raw;

  logic [LEAD_W-1:0] lead_bits;
  logic              lead_pending;
  logic              skipping;
  logic [LEAD_W-1:0] lead_bits_next;
  logic              lead_pending_next;
  logic              skipping_next;

  assign ready         = !stage.valid || next_ready;
  assign byte_ch.ready = ready;
  assign fire          = byte_ch.valid && ready;
  assign cont          = byte_ch.byte_in[7:6] == 2'b10;

  always_comb begin
    emit              = 1'b0;
    raw               = '0;
    lead_bits_next    = lead_bits;
    lead_pending_next = lead_pending;
    skipping_next     = skipping;
    if (lead_pending) begin
      // Follower completes the pair whatever its top bits are.
      emit              = 1'b1;
      raw               = {lead_bits, byte_ch.byte_in[5:0]};
      lead_pending_next = 1'b0;
    end else if (skipping && cont) begin
      emit = 1'b0;
    end else begin
      skipping_next = 1'b0;
      if (byte_ch.byte_in <= ASCII_MAX) begin
        emit = 1'b1;
        raw  = CODE_W'(byte_ch.byte_in);
      end else if (byte_ch.byte_in >= LEAD_MIN && byte_ch.byte_in <= LEAD_MAX) begin
        if (byte_ch.last_byte) begin
          emit = 1'b1;
        end else begin
          lead_bits_next    = byte_ch.byte_in[LEAD_W-1:0];
          lead_pending_next = 1'b1;
        end
      end else begin
        // Stray continuation or unsupported lead: blank code, skip after a lead.
        skipping_next = byte_ch.byte_in > LEAD_MAX;
        emit          = 1'b1;
      end
    end
    if (byte_ch.last_byte) begin
      lead_pending_next = 1'b0;
      skipping_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid  <= 1'b0;
      lead_bits    <= '0;
      lead_pending <= 1'b0;
      skipping     <= 1'b0;
    end else begin
      if (ready) begin
        stage.valid <= fire && emit;
        stage.code  <= raw;
      end
      if (fire) begin
        lead_bits    <= lead_bits_next;
        lead_pending <= lead_pending_next;
        skipping     <= skipping_next;
      end
    end
  end

`ifndef SYNTH
  a_pending_skip_excl: assert property (@(posedge clk) disable iff (rst)
    !(lead_pending && skipping))
    else $error("lead held while skipping continuations");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    fire && byte_ch.last_byte |=> !lead_pending && !skipping)
    else $error("decoder state survives end of string");
`endif

endmodule

@@ src/utfga_remap.sv @@
// Remap stage: applies the remap ranges in order and registers the code.
module utfga_remap #(
  parameter int REMAP_RANGES = utfga_pkg::REMAP_RANGES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  utfga_pkg::code_stage_t               in_stage,
  input  utfga_pkg::remap_t [REMAP_RANGES-1:0] remap,
  input  logic                                 next_ready,
  output logic                                 ready,
  output utfga_pkg::code_stage_t               stage
);
  import utfga_pkg::*;

  logic [CODE_W-1:0] code;

  assign ready = !stage.valid || next_ready;

  always_comb begin
    code = in_stage.code;
    // Each later range sees the earlier result.
    for (int i = 0; i < REMAP_RANGES; i++) begin
      if (code >= remap[i].lo && code <= remap[i].hi) begin
        code = code - remap[i].lo + remap[i].target;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (ready) begin
      stage.valid <= in_stage.valid;
      stage.code  <= code;
    end
  end

endmodule

@@ src/utfga_glyph.sv @@
// Glyph stage: range search, ROM address and blank columns into the result register.
module utfga_glyph #(
  parameter int FONT_RANGES = utfga_pkg::FONT_RANGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  utfga_pkg::code_stage_t             in_stage,
  input  utfga_pkg::font_t [FONT_RANGES-1:0] font,
  output logic                               ready,
  utfga_glyph_if.source                      glyph_ch
);
  import utfga_pkg::*;

  logic                 hit;
  font_t                sel;
  logic [WIDTH_W-1:0]   w;
  logic [CODE_W-1:0]    offset;
  logic [CODE_W+WIDTH_W-1:0] prod;
  logic [KIND_W-1:0]    kind;
  logic [ADDR_W-1:0]    addr;
  logic [BLANK_W-1:0]   blank;

  assign ready = !glyph_ch.valid || glyph_ch.ready;

  always_comb begin
    hit = 1'b0;
    sel = font[0];
    // Walk from the back so the first matching range wins.
    for (int i = FONT_RANGES - 1; i >= 0; i--) begin
      if (in_stage.code >= font[i].lo && in_stage.code <= font[i].hi) begin
        hit = 1'b1;
        sel = font[i];
      end
    end
    w      = clamp_width(sel.width);
    offset = in_stage.code - sel.lo;
    prod   = (CODE_W+WIDTH_W)'(offset) * (CODE_W+WIDTH_W)'(w);
    kind   = GLYPH_BOX;
    addr   = '0;
    blank  = '0;
    if (in_stage.code == '0) begin
      kind = GLYPH_BLANK;
    end else if (hit) begin
      kind  = GLYPH_FONT;
      addr  = sel.base + ADDR_W'(prod);
      blank = BLANK_W'(WIDTH_MAX - w);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_ch.valid <= 1'b0;
    end else if (ready) begin
      glyph_ch.valid         <= in_stage.valid;
      glyph_ch.code_point    <= in_stage.code;
      glyph_ch.glyph_kind    <= kind;
      glyph_ch.rom_address   <= addr;
      glyph_ch.blank_columns <= blank;
    end
  end

`ifndef SYNTH
  a_zero_is_blank: assert property (@(posedge clk) disable iff (rst)
    glyph_ch.valid && glyph_ch.code_point == '0 |-> glyph_ch.glyph_kind == GLYPH_BLANK)
    else $error("code zero not shown as blank glyph");

  a_no_font_no_addr: assert property (@(posedge clk) disable iff (rst)
    glyph_ch.valid && glyph_ch.glyph_kind != GLYPH_FONT
      |-> glyph_ch.rom_address == '0 && glyph_ch.blank_columns == '0)
    else $error("address given for blank or box glyph");
`endif

endmodule

@@ src/utf8_glyph_address_stream_core.sv @@
// Top level: a byte that gives a result reaches the result register through the decode, remap
// and glyph registers; a lead waits for its follower.
// One byte is accepted every cycle while ready is high; the ready chain through the decode,
// remap and glyph registers stalls only when the result register is full and not taken.
// Reset (synchronous, active high) clears the decoder state, the stage valid bits
// and all range registers to zero.
module utf8_glyph_address_stream_core #(
  parameter int REMAP_RANGES = utfga_pkg::REMAP_RANGES_DEF,
  parameter int FONT_RANGES  = utfga_pkg::FONT_RANGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  utfga_byte_if.sink                        byte_ch,
  utfga_glyph_if.source                     glyph_ch,
  input  logic                              cfg_write,
  input  logic [utfga_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [utfga_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import utfga_pkg::*;

  remap_t [REMAP_RANGES-1:0] remap;
  font_t  [FONT_RANGES-1:0]  font;
  code_stage_t               raw_stage;
  code_stage_t               mapped_stage;
  logic                      remap_ready;
  logic                      glyph_ready;

  utfga_cfg #(
    .REMAP_RANGES (REMAP_RANGES),
    .FONT_RANGES  (FONT_RANGES)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .remap     (remap),
    .font      (font)
  );

  utfga_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .byte_ch    (byte_ch),
    .next_ready (remap_ready),
    .stage      (raw_stage)
  );

  utfga_remap #(
    .REMAP_RANGES (REMAP_RANGES)
  ) u_remap (
    .clk        (clk),
    .rst        (rst),
    .in_stage   (raw_stage),
    .remap      (remap),
    .next_ready (glyph_ready),
    .ready      (remap_ready),
    .stage      (mapped_stage)
  );

  utfga_glyph #(
    .FONT_RANGES (FONT_RANGES)
  ) u_glyph (
    .clk      (clk),
    .rst      (rst),
    .in_stage (mapped_stage),
    .font     (font),
    .ready    (glyph_ready),
    .glyph_ch (glyph_ch)
  );

endmodule
